[rtl/core/tbmp_pkg.sv]
// package for the touch button multi-press resolver
// word widths, field layout and defaults; no dependencies
package tbmp_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int NUM_DIFFS       = 5;
    localparam int DIFF_W          = 16;
    localparam int MASK_W          = 5;

    // input word: raw_mask, diff_0 .. diff_4, zero fill to whole bytes
    localparam int IN_FIELDS_W = MASK_W + NUM_DIFFS * DIFF_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // output word: valid_mask, new_presses, zero fill to whole bytes
    localparam int OUT_FIELDS_W = 2 * MASK_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [DIFF_W-1:0] diff_t;
    typedef logic [MASK_W-1:0] mask_t;

    // pipeline handshake state between input and result stages
    typedef struct packed {
        logic in_valid;
        logic advance;
    } stage_ctl_t;

endpackage

[rtl/core/touch_button_multi_press_resolver.sv]
// top level of the touch button multi-press resolver
// depends on tbmp_pkg
//
// Each input word carries one scan: the raw touch mask of the buttons and the
// difference count of every button. The block keeps at most one button active:
// a single touched button passes as it is; with several touched, buttons are
// resolved in rising index order, a button held in the previous validated mask
// beats a new one, and between new buttons the larger count wins, a tie going
// to the lower index. The output word gives the validated mask and the bits
// that rose against the previous validated mask. Each word passes an input
// register, then a result register, and one word is accepted every cycle while
// the output side takes words; the resolution is a short index chain over
// pairwise count compares that are all done in parallel.
module touch_button_multi_press_resolver
    import tbmp_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // raw_mask[4:0], diff_0, diff_1, diff_2, diff_3, diff_4, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // valid_mask[4:0], new_presses[4:0], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(NUM_BUTTONS);
    localparam int LV_W  = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

    stage_ctl_t             ctl;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [IN_TDATA_W-1:0]  s1_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mask_t                  valid_mask_reg;
    mask_t                  new_presses_reg;
    logic [LV_W-1:0]        last_valid_reg;
    logic [LV_W-1:0]        last_valid_next;

    logic [NUM_BUTTONS-1:0] raw_w;
    logic [NUM_BUTTONS-1:0] prev_w;
    diff_t                  diff_w [NUM_BUTTONS];
    logic                   lt_w   [NUM_BUTTONS][NUM_BUTTONS];
    logic [IDX_W-1:0]       champ;
    logic                   found;
    logic [NUM_BUTTONS-1:0] valid_w;
    mask_t                  valid5;
    mask_t                  last5;
    mask_t                  new5;

    // handshake
    assign ctl.in_valid  = s1_valid_reg;
    assign ctl.advance   = ctl.in_valid && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || ctl.advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // field extraction from the input register
    genvar gi, gj;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++)
        begin : g_btn
            if (gi < MASK_W)
            begin : g_raw
                assign raw_w[gi] = s1_data_reg[gi];
            end
            else
            begin : g_noraw
                assign raw_w[gi] = 1'b0;
            end
            if (gi < LV_W)
            begin : g_prev
                assign prev_w[gi] = last_valid_reg[gi];
            end
            else
            begin : g_noprev
                assign prev_w[gi] = 1'b0;
            end
            if (gi < NUM_DIFFS)
            begin : g_diff
                assign diff_w[gi] = s1_data_reg[MASK_W + gi*DIFF_W +: DIFF_W];
            end
            else
            begin : g_nodiff
                assign diff_w[gi] = '0;
            end
        end
        // all pairwise compares in parallel
        for (gi = 0; gi < NUM_BUTTONS; gi++)
        begin : g_row
            for (gj = 0; gj < NUM_BUTTONS; gj++)
            begin : g_col
                assign lt_w[gi][gj] = diff_w[gi] < diff_w[gj];
            end
        end
    endgenerate

    // surviving button, scanned upward
    always_comb
    begin
        champ = '0;
        found = 1'b0;
        for (int c = 0; c < NUM_BUTTONS; c++)
        begin
            if (raw_w[c])
            begin
                if (!found)
                begin
                    champ = IDX_W'(c);
                    found = 1'b1;
                end
                else if (prev_w[c])
                begin
                    champ = IDX_W'(c);
                end
                else if (!prev_w[champ] && lt_w[champ][c])
                begin
                    champ = IDX_W'(c);
                end
            end
        end
    end

    always_comb
    begin
        valid_w = '0;
        if (found)
        begin
            valid_w[champ] = 1'b1;
        end
    end

    always_comb
    begin
        valid5 = '0;
        last5  = '0;
        for (int i = 0; i < LV_W; i++)
        begin
            valid5[i] = valid_w[i];
            last5[i]  = last_valid_reg[i];
        end
    end

    assign new5            = valid5 & ~last5;
    assign last_valid_next = valid5[LV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (ctl.advance)
            begin
                last_valid_reg <= last_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_data_reg <= s_axis_tdata;
        end
        if (ctl.advance)
        begin
            valid_mask_reg  <= valid5;
            new_presses_reg <= new5;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, new_presses_reg, valid_mask_reg};

    // at most one button survives
    a_onehot_mask : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(valid_mask_reg))
        else $error("more than one validated button");

    // rising bits are a subset of the validated mask
    a_new_subset : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((new_presses_reg & ~valid_mask_reg) == '0))
        else $error("new press outside validated mask");

    // history follows the word just produced
    a_history : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance |=> (last_valid_reg == valid_mask_reg[LV_W-1:0]))
        else $error("last validated mask out of step with output");

    // a rising bit was clear in the history before the update
    a_new_rise : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance |=> ((new_presses_reg[LV_W-1:0] & $past(last_valid_reg)) == '0))
        else $error("held button reported as new press");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for touch_button_multi_press_resolver
// depends on tbmp_pkg; a scoreboard class predicts each scan's validated mask
module tb;

    import tbmp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SCAN_COUNT  = 850;

    typedef logic [OUT_TDATA_W-1:0] result_word_t;
    typedef diff_t [NUM_DIFFS-1:0]  counts_t;

    class press_scoreboard;
        mask_t        held;
        result_word_t expected_words[$];
        int           errors;

        function new();
            held   = '0;
            errors = 0;
        endfunction

        // pairwise resolution, lower index first; held beats new, larger count beats smaller
        function mask_t resolve_presses(mask_t raw, counts_t diff);
            mask_t mask;
            mask = raw;
            for (int b = 0; b < NUM_BUTTONS_DEF - 1; b++)
            begin
                if (!mask[b])
                    continue;
                for (int c = b + 1; c < NUM_BUTTONS_DEF; c++)
                begin
                    if (!mask[c])
                        continue;
                    if (held[c])
                    begin
                        mask[b] = 1'b0;
                        break;
                    end
                    else if (held[b])
                        mask[c] = 1'b0;
                    else if (diff[b] < diff[c])
                    begin
                        mask[b] = 1'b0;
                        break;
                    end
                    else
                        mask[c] = 1'b0;
                end
            end
            return mask;
        endfunction

        function void note_scan(mask_t raw, counts_t diff);
            mask_t        valid;
            mask_t        buttons;
            result_word_t word;
            buttons = mask_t'((1 << NUM_BUTTONS_DEF) - 1);
            raw     = raw & buttons;
            if ($countones(raw) <= 1)
                valid = raw;
            else
                valid = resolve_presses(raw, diff);
            word = '0;
            word[MASK_W-1:0]        = valid;
            word[2*MASK_W-1:MASK_W] = valid & ~held;
            expected_words.push_back(word);
            held = valid;
        endfunction

        function void check_word(result_word_t got);
            result_word_t exp;
            if (expected_words.size() == 0)
            begin
                $display("[%0t] result %h arrived with no scan waiting", $time, got);
                errors++;
                return;
            end
            exp = expected_words.pop_front();
            if (got[MASK_W-1:0] !== exp[MASK_W-1:0])
            begin
                $display("[%0t] valid_mask expected %h got %h", $time,
                         exp[MASK_W-1:0], got[MASK_W-1:0]);
                errors++;
            end
            if (got[2*MASK_W-1:MASK_W] !== exp[2*MASK_W-1:MASK_W])
            begin
                $display("[%0t] new_presses expected %h got %h", $time,
                         exp[2*MASK_W-1:MASK_W], got[2*MASK_W-1:MASK_W]);
                errors++;
            end
            if (got[OUT_TDATA_W-1:2*MASK_W] !== exp[OUT_TDATA_W-1:2*MASK_W])
            begin
                $display("[%0t] zero fill expected %h got %h", $time,
                         exp[OUT_TDATA_W-1:2*MASK_W], got[OUT_TDATA_W-1:2*MASK_W]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    press_scoreboard sb;
    int              cycles = 0;
    int              rx_stall = 0;
    bit              steady = 1'b0;

    touch_button_multi_press_resolver uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic counts_t pack_counts(diff_t d0, diff_t d1, diff_t d2, diff_t d3,
                                            diff_t d4);
        return {d4, d3, d2, d1, d0};
    endfunction

    function automatic mask_t multi_press();
        mask_t m;
        do
            m = mask_t'($urandom);
        while ($countones(m) < 2);
        return m;
    endfunction

    // result side
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_word(m_axis_tdata);
            rx_stall = draw_gap();
        end
    end

    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_scan(input mask_t raw, input counts_t diff);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        gap  = draw_gap();
        word = '0;
        word[MASK_W-1:0] = raw;
        for (int i = 0; i < NUM_DIFFS; i++)
            word[MASK_W + i*DIFF_W +: DIFF_W] = diff[i];
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_scan(raw, diff);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        mask_t   raw;
        counts_t diff;
        int      kind;

        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed scans
        send_scan(5'h00, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h1F, pack_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_scan(5'h1F, pack_counts(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_scan(5'h00, pack_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_scan(5'h1F, pack_counts(16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF));
        send_scan(5'h03, pack_counts(16'h0005, 16'h0005, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h10, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h11, pack_counts(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h18, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
        send_scan(5'h01, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h05, pack_counts(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
        send_scan(5'h02, pack_counts(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_scan(5'h04, pack_counts(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_scan(5'h08, pack_counts(16'h0001, 16'h8000, 16'h0001, 16'h8000, 16'h0001));
        send_scan(5'h00, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h1E, pack_counts(16'h0000, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_scan(5'h00, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h0C, pack_counts(16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 16'h0000));
        send_scan(5'h1F, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h00, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h1F, pack_counts(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_scan(5'h14, pack_counts(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000));
        drain_results();

        // random scans, mostly multi-press
        for (int n = 0; n < SCAN_COUNT; n++)
        begin
            steady = ((n / 60) % 4 == 1);
            if (n == SCAN_COUNT / 2)
                drain_results();
            kind = $urandom_range(0, 9);
            for (int i = 0; i < NUM_DIFFS; i++)
                diff[i] = (kind == 6) ? diff_t'($urandom_range(0, 2)) : diff_t'($urandom);
            case (kind)
                0:       raw = mask_t'($urandom);
                1, 2:    raw = $urandom_range(0, 1) ? mask_t'(1 << $urandom_range(0, 4)) : '0;
                3, 4, 5,
                6:       raw = multi_press();
                default:
                begin
                    do
                        raw = sb.held | mask_t'($urandom);
                    while ($countones(raw) < 2);
                end
            endcase
            send_scan(raw, diff);
        end
        steady = 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
